FILE: src/sstf_pkg.sv
// Package for the shortest-seek-time-first disk scheduler.
// Holds field widths, the parameter default and the request, result, config and scan types.
// No dependencies; sstf_nearest and sstf_disk_scheduler import it.
`default_nettype none

package sstf_pkg;

  localparam int TRACK_W         = 16;
  localparam int SLOT_W          = 6;
  localparam int TOTAL_W         = 22;
  localparam int MAX_PENDING_DEF = 64;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               batch_last;
  } in_req_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [SLOT_W-1:0]  served_slot;
    logic [TRACK_W-1:0] seek_distance;
    logic [TOTAL_W-1:0] total_movement;
    logic               last_of_run;
    logic               overflowed;
  } out_res_t;

  typedef struct packed {
    logic [TRACK_W-1:0] start_track;
  } cfg_wr_t;

  // Best candidate found so far in one scan over the stored requests.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TRACK_W-1:0] seek;
    logic [TRACK_W-1:0] track;
  } best_t;

endpackage

`default_nettype wire

FILE: src/sstf_chan_if.sv
// Valid/ready channel interface used for the request, result and configuration ports.
// The payload type is a parameter; the types come from sstf_pkg.
`default_nettype none

interface sstf_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: src/sstf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the request store; depends on nothing.
`default_nettype none

module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/sstf_nearest.sv
// Shared distance and compare unit: takes one stored request per cycle and keeps
// the nearest unserved one to the head. Depends on sstf_pkg.
`default_nettype none

module sstf_nearest (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clr,
  input  wire logic                    smp,
  input  wire logic [sstf_pkg::TRACK_W-1:0] smp_track,
  input  wire logic [sstf_pkg::SLOT_W-1:0]  smp_slot,
  input  wire logic                    smp_served,
  input  wire logic [sstf_pkg::TRACK_W-1:0] head,
  output sstf_pkg::best_t              best
);

  import sstf_pkg::*;

  logic               found_r;
  logic               found_nxt;
  best_t              best_r;
  best_t              best_nxt;
  logic [TRACK_W-1:0] seek;
  logic               take;

  always_comb begin
    seek      = (smp_track > head) ? (smp_track - head) : (head - smp_track);
    take      = smp && !smp_served && (!found_r || (seek < best_r.seek));
    found_nxt = found_r;
    best_nxt  = best_r;
    if (clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt      = 1'b1;
      best_nxt.slot  = smp_slot;
      best_nxt.seek  = seek;
      best_nxt.track = smp_track;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_r <= best_nxt;
  end

  assign best = best_r;

endmodule

`default_nettype wire

FILE: src/sstf_disk_scheduler.sv
// Shortest-seek-time-first disk scheduler, top level.
// Depends on sstf_pkg, sstf_chan_if, sstf_ram and sstf_nearest.
//
// Usage:
//   in_ch carries one request (track, batch_last). While loading, in_ch.ready is
//   high and a request is taken every cycle. Requests beyond MAX_PENDING are
//   dropped and flag overflowed on every result of that batch.
//   The request with batch_last closes the batch; start_track is sampled then.
//   out_ch delivers one result per stored request, nearest unserved track first,
//   ties to the lowest slot, last_of_run on the final one.
//   cfg_ch writes start_track and is always ready.
// Timing:
//   Each service scans the n stored requests through one registered RAM read
//   port and one shared compare unit; the scan for the next result starts only
//   after the previous one is emitted. in_ch.ready stays low until the batch is served.
//   A finished result waits in the output register; if out_ch stalls, the
//   next result waits until the register is taken.
// Reset:
//   rst_n clears the batch, the head, start_track and the output valid. The
//   request store needs no clearing.
`default_nettype none

module sstf_disk_scheduler #(
  parameter int MAX_PENDING = sstf_pkg::MAX_PENDING_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  sstf_chan_if.sink   in_ch,
  sstf_chan_if.source out_ch,
  sstf_chan_if.sink   cfg_ch
);

  import sstf_pkg::*;

  localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CNT_W = $clog2(MAX_PENDING + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic [CNT_W-1:0]       serve_r, serve_nxt;
  logic [TRACK_W-1:0]     head_r, head_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [TRACK_W-1:0]     start_r;
  logic [MAX_PENDING-1:0] served_r, served_nxt;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   out_vld_r, out_vld_nxt;
  out_res_t               out_data_r, out_data_nxt;

  logic               in_fire;
  logic               wr_en;
  logic               issuing;
  logic               clr;
  logic               emit_go;
  logic               last_svc;
  logic [TOTAL_W-1:0] sum;
  logic [TRACK_W-1:0] rd_data;
  best_t              best;

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign wr_en        = in_fire && (cnt_r < CNT_W'(MAX_PENDING));
  assign issuing      = (state_r == ST_SCAN) && (issue_r < cnt_r);
  assign emit_go      = (state_r == ST_EMIT) && (!out_vld_r || out_ch.ready);
  assign last_svc     = (serve_r == (cnt_r - CNT_W'(1)));
  assign sum          = total_r + TOTAL_W'(best.seek);

  sstf_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (MAX_PENDING)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_ch.payload.request_track),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  sstf_nearest u_nearest (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .smp        (rd_vld_r),
    .smp_track  (rd_data),
    .smp_slot   (SLOT_W'(rd_idx_r)),
    .smp_served (served_r[rd_idx_r]),
    .head       (head_r),
    .best       (best)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    issue_nxt    = issue_r;
    serve_nxt    = serve_r;
    head_nxt     = head_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    served_nxt   = served_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_data_nxt = out_data_r;
    clr          = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.payload.batch_last) begin
            state_nxt = ST_SCAN;
            head_nxt  = start_r;
            total_nxt = '0;
            issue_nxt = '0;
            serve_nxt = '0;
            clr       = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_nxt = issue_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_vld_nxt                 = 1'b1;
          out_data_nxt.served_track   = best.track;
          out_data_nxt.served_slot    = best.slot;
          out_data_nxt.seek_distance  = best.seek;
          out_data_nxt.total_movement = sum;
          out_data_nxt.last_of_run    = last_svc;
          out_data_nxt.overflowed     = ovf_r;
          head_nxt                    = best.track;
          if (last_svc) begin
            state_nxt  = ST_LOAD;
            cnt_nxt    = '0;
            serve_nxt  = '0;
            total_nxt  = '0;
            ovf_nxt    = 1'b0;
            served_nxt = '0;
          end else begin
            state_nxt                        = ST_SCAN;
            serve_nxt                        = serve_r + CNT_W'(1);
            total_nxt                        = sum;
            issue_nxt                        = '0;
            served_nxt[best.slot[IDX_W-1:0]] = 1'b1;
            clr                              = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      issue_r   <= '0;
      serve_r   <= '0;
      head_r    <= '0;
      total_r   <= '0;
      ovf_r     <= 1'b0;
      start_r   <= '0;
      served_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      issue_r   <= issue_nxt;
      serve_r   <= serve_nxt;
      head_r    <= head_nxt;
      total_r   <= total_nxt;
      ovf_r     <= ovf_nxt;
      served_r  <= served_nxt;
      rd_vld_r  <= issuing;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        start_r <= cfg_ch.payload.start_track;
      end
    end
    rd_idx_r   <= issue_r[IDX_W-1:0];
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_data_r;

endmodule

`default_nettype wire
